// ----- src/nal_egw_pkg.sv -----
// ----------------------------------------------------------------------------
// nal_egw_pkg
// Shared types and constants for the NAL Exp-Golomb bit writer.
// ----------------------------------------------------------------------------
package nal_egw_pkg;

  // Command codes carried on the cmd field.
  typedef enum logic [2:0] {
    CMD_OPEN   = 3'd0,
    CMD_FIXED  = 3'd1,
    CMD_UE     = 3'd2,
    CMD_SE     = 3'd3,
    CMD_FINISH = 3'd4,
    CMD_FLUSH  = 3'd5
  } cmd_t;

  // What the emitter has to do with one decoded command.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_OPEN,
    KIND_BITS,
    KIND_FINISH,
    KIND_FLUSH
  } kind_t;

  // Longest bit string one command appends: se(v) of the most negative value.
  localparam int unsigned MAX_BITS   = 65;
  localparam int unsigned NBITS_W    = 7;
  // Bit accumulator: up to seven pending bits plus one full command string.
  localparam int unsigned ACC_W      = 72;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned REPORT_W   = 24;

  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] BYTE_EPB    = 8'h03;

  // Decoded command handed from the decoder to the emitter.
  typedef struct packed {
    kind_t                kind;
    logic [MAX_BITS-1:0]  bits;     // right aligned, MSB written first
    logic [NBITS_W-1:0]   nbits;    // 0 to 65
    logic [7:0]           header;   // NAL header byte for an open
    logic                 prevent;  // emulation prevention enable for an open
  } desc_t;

endpackage

// ----- src/nal_egw_decode.sv -----
// ----------------------------------------------------------------------------
// nal_egw_decode
// Turns one command into a bit string and length and holds it in a register.
// ----------------------------------------------------------------------------
module nal_egw_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           cmd,
  input  logic [31:0]          value,
  input  logic [5:0]           field_width,
  input  logic [1:0]           ref_idc,
  input  logic [4:0]           unit_type,
  input  logic                 prevent_emulation,
  output logic                 desc_valid,
  output nal_egw_pkg::desc_t   desc,
  input  logic                 desc_take
);

  nal_egw_pkg::desc_t desc_next;
  logic [32:0]        code;
  logic [32:0]        code_plus;
  logic [5:0]         code_len;
  logic [5:0]         fixed_n;

  // Bit length of the Exp-Golomb info word; the highest set bit wins.
  function automatic logic [5:0] word_len(input logic [32:0] v);
    logic [5:0] len;
    len = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) begin
        len = 6'(i + 1);
      end
    end
    return len;
  endfunction

  always_comb begin
    // Signed values map to 2v-1 for positive and 2|v| for negative.
    if (cmd == nal_egw_pkg::CMD_SE) begin
      if (value == 32'd0) begin
        code = 33'd0;
      end else if (!value[31]) begin
        code = {value, 1'b0} - 33'd1;
      end else begin
        code = {(~value + 32'd1), 1'b0};
      end
    end else begin
      code = {1'b0, value};
    end
    // The code never exceeds 2^32, so the info word fits in 33 bits.
    code_plus = code + 33'd1;
    code_len  = word_len(code_plus);
    fixed_n   = (field_width > 6'd32) ? 6'd32 : field_width;
  end

  always_comb begin
    desc_next.kind    = nal_egw_pkg::KIND_NONE;
    desc_next.bits    = '0;
    desc_next.nbits   = '0;
    desc_next.header  = {1'b0, ref_idc, unit_type};
    desc_next.prevent = prevent_emulation;
    case (cmd)
      nal_egw_pkg::CMD_OPEN: begin
        desc_next.kind = nal_egw_pkg::KIND_OPEN;
      end
      nal_egw_pkg::CMD_FIXED: begin
        desc_next.kind  = nal_egw_pkg::KIND_BITS;
        desc_next.bits  = {33'd0, value} & ((65'd1 << fixed_n) - 65'd1);
        desc_next.nbits = {1'b0, fixed_n};
      end
      nal_egw_pkg::CMD_UE, nal_egw_pkg::CMD_SE: begin
        // Leading zeros plus the info word is the word itself in 2*len-1 bits.
        desc_next.kind  = nal_egw_pkg::KIND_BITS;
        desc_next.bits  = {32'd0, code_plus};
        desc_next.nbits = {code_len, 1'b0} - 7'd1;
      end
      nal_egw_pkg::CMD_FINISH: begin
        desc_next.kind = nal_egw_pkg::KIND_FINISH;
      end
      nal_egw_pkg::CMD_FLUSH: begin
        desc_next.kind = nal_egw_pkg::KIND_FLUSH;
      end
      default: begin
        desc_next.kind = nal_egw_pkg::KIND_NONE;
      end
    endcase
  end

  assign in_ready = !desc_valid || desc_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (in_ready) begin
      desc_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      desc <= desc_next;
    end
  end

endmodule

// ----- src/nal_egw_emit.sv -----
// ----------------------------------------------------------------------------
// nal_egw_emit
// Bit accumulator, emulation prevention and the registered result stage.
// ----------------------------------------------------------------------------
module nal_egw_emit #(
  parameter int unsigned BIT_TOTAL_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 desc_valid,
  input  nal_egw_pkg::desc_t   desc,
  output logic                 desc_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 byte_valid,
  output logic                 last,
  output logic [23:0]          nal_bits
);

  localparam int unsigned W  = BIT_TOTAL_WIDTH;
  localparam int unsigned RW = BIT_TOTAL_WIDTH + nal_egw_pkg::REPORT_W;

  logic [nal_egw_pkg::ACC_W-1:0]    acc, acc_next;
  logic [nal_egw_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [1:0]                       zero_run, zero_run_next;
  logic                             prevention_on, prevention_on_next;
  logic [W-1:0]                     bit_total, bit_total_next;
  logic [nal_egw_pkg::REPORT_W-1:0] report, report_next;
  logic                             raw, raw_next;
  logic                             close, close_next;
  logic                             null_pend, null_pend_next;

  logic                             idle;
  logic                             have_out;
  logic                             advance;
  logic                             epb;
  logic [7:0]                       top;
  logic [2:0]                       pcnt;
  logic [nal_egw_pkg::NBITS_W-1:0]  shamt;
  logic [W-1:0]                     t_one;
  logic [7:0]                       res_byte;
  logic                             res_last;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a,
                                           input logic [nal_egw_pkg::NBITS_W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + (W + 1)'(b);
    return s[W] ? {W{1'b1}} : s[W-1:0];
  endfunction

  function automatic logic [nal_egw_pkg::REPORT_W-1:0] to_report(input logic [W-1:0] x);
    logic [RW-1:0] ext;
    ext = RW'(x);
    if (ext > RW'(24'hFFFFFF)) begin
      return 24'hFFFFFF;
    end
    return ext[nal_egw_pkg::REPORT_W-1:0];
  endfunction

  assign pcnt      = cnt[2:0];
  assign top       = acc[nal_egw_pkg::ACC_W-1 -: 8];
  assign have_out  = (cnt >= 7'd8) || null_pend;
  assign idle      = !have_out;
  assign desc_take = desc_valid && idle;
  assign advance   = have_out && (!out_valid || out_ready);
  assign epb       = prevention_on && !raw && !null_pend && (zero_run == 2'd2) &&
                     (top <= nal_egw_pkg::BYTE_EPB);
  assign shamt     = 7'(nal_egw_pkg::ACC_W) - {4'd0, pcnt} - desc.nbits;
  assign t_one     = sat_add(bit_total, 7'd1);

  always_comb begin
    if (null_pend) begin
      res_byte = nal_egw_pkg::BYTE_ZERO;
    end else if (epb) begin
      res_byte = nal_egw_pkg::BYTE_EPB;
    end else begin
      res_byte = top;
    end
    res_last = null_pend || (close && (cnt == 7'd8) && !epb);
  end

  always_comb begin
    acc_next           = acc;
    cnt_next           = cnt;
    zero_run_next      = zero_run;
    prevention_on_next = prevention_on;
    bit_total_next     = bit_total;
    report_next        = report;
    raw_next           = raw;
    close_next         = close;
    null_pend_next     = null_pend;

    if (desc_take) begin
      raw_next   = 1'b0;
      close_next = 1'b0;
      case (desc.kind)
        nal_egw_pkg::KIND_OPEN: begin
          acc_next = {nal_egw_pkg::BYTE_ZERO, nal_egw_pkg::BYTE_ZERO,
                      nal_egw_pkg::BYTE_ZERO, nal_egw_pkg::BYTE_ONE,
                      desc.header, 32'd0};
          cnt_next           = 7'd40;
          raw_next           = 1'b1;
          zero_run_next      = 2'd0;
          prevention_on_next = desc.prevent;
          bit_total_next     = sat_add('0, 7'd40);
          report_next        = to_report(sat_add('0, 7'd40));
        end
        nal_egw_pkg::KIND_BITS: begin
          acc_next       = acc | ({7'd0, desc.bits} << shamt);
          cnt_next       = cnt + desc.nbits;
          bit_total_next = sat_add(bit_total, desc.nbits);
          report_next    = to_report(sat_add(bit_total, desc.nbits));
        end
        nal_egw_pkg::KIND_FINISH: begin
          // Stop bit, then the byte is padded with zeros to its end.
          acc_next       = acc | (72'd1 << (7'd71 - {4'd0, pcnt}));
          cnt_next       = 7'd8;
          close_next     = 1'b1;
          report_next    = to_report(t_one);
          bit_total_next = sat_add(t_one, 7'd7 - {4'd0, pcnt});
        end
        nal_egw_pkg::KIND_FLUSH: begin
          report_next = to_report(bit_total);
          if (pcnt != 3'd0) begin
            cnt_next       = 7'd8;
            close_next     = 1'b1;
            bit_total_next = sat_add(bit_total, 7'd8 - {4'd0, pcnt});
          end else begin
            null_pend_next = 1'b1;
          end
        end
        default: begin
          raw_next   = raw;
          close_next = close;
        end
      endcase
    end else if (advance) begin
      if (null_pend) begin
        null_pend_next = 1'b0;
      end else if (epb) begin
        zero_run_next = 2'd0;
      end else begin
        acc_next = acc << 8;
        cnt_next = cnt - 7'd8;
        if (!raw) begin
          if (top == nal_egw_pkg::BYTE_ZERO) begin
            zero_run_next = (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
          end else begin
            zero_run_next = 2'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      cnt           <= '0;
      zero_run      <= '0;
      prevention_on <= 1'b0;
      bit_total     <= '0;
      report        <= '0;
      raw           <= 1'b0;
      close         <= 1'b0;
      null_pend     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      acc           <= acc_next;
      cnt           <= cnt_next;
      zero_run      <= zero_run_next;
      prevention_on <= prevention_on_next;
      bit_total     <= bit_total_next;
      report        <= report_next;
      raw           <= raw_next;
      close         <= close_next;
      null_pend     <= null_pend_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= res_byte;
      byte_valid <= !null_pend;
      last       <= res_last;
      nal_bits   <= report;
    end
  end

endmodule

// ----- src/nal_exp_golomb_bit_writer.sv -----
// ----------------------------------------------------------------------------
// nal_exp_golomb_bit_writer
// H.264 NAL unit byte stream writer with Exp-Golomb coding and emulation
// prevention.
// ----------------------------------------------------------------------------
// Flow: a command is registered in the decoder, merged into the emitter
//   accumulator, and its result bytes then go through the output register.
// Throughput: the byte emitter puts out one byte a cycle while the output
//   is not stalled, and takes the next command once its bytes are drained.
// Reset: rst is synchronous and active high; it empties both stages and
//   clears the pending bits, zero run, prevention enable and bit count.
module nal_exp_golomb_bit_writer #(
  parameter int unsigned BIT_TOTAL_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [31:0] value,
  input  logic [5:0]  field_width,
  input  logic [1:0]  ref_idc,
  input  logic [4:0]  unit_type,
  input  logic        prevent_emulation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [23:0] nal_bits
);

  // The decoder registers each command as a right-aligned bit string with
  // its length. The Exp-Golomb code of v is simply v+1 written in
  // 2*len(v+1)-1 bits, so no separate prefix pass is needed.
  logic               desc_valid;
  logic               desc_take;
  nal_egw_pkg::desc_t desc;

  nal_egw_decode u_decode (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .value             (value),
    .field_width       (field_width),
    .ref_idc           (ref_idc),
    .unit_type         (unit_type),
    .prevent_emulation (prevent_emulation),
    .desc_valid        (desc_valid),
    .desc              (desc),
    .desc_take         (desc_take)
  );

  // The emitter merges the bit string under the pending partial byte in a
  // left-aligned accumulator and then drains whole bytes, one per cycle
  // while the output is not stalled. An emulation prevention byte is sent in
  // a cycle of its own ahead of the byte that triggered it. The next command
  // is taken as soon as fewer than eight bits remain and no empty flush is
  // pending, while the last result may still wait in the output register.
  nal_egw_emit #(
    .BIT_TOTAL_WIDTH (BIT_TOTAL_WIDTH)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .nal_bits   (nal_bits)
  );

  // An empty flush report is always the final result and carries a zero byte.
  a_null_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (last && (out_byte == 8'h00)))
    else $error("empty flush result without last or with nonzero byte");

  // A command is only handed to the emitter when one is held.
  a_take_needs_desc: assert property (@(posedge clk) disable iff (rst)
    desc_take |-> desc_valid)
    else $error("emitter took a command that was not there");

  // Both stages come out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !desc_valid))
    else $error("pipeline not empty after reset");

endmodule
